@@ hw/rtl/mqrrs_pkg.sv @@
package mqrrs_pkg;

   localparam int TASK_W = 6;
   localparam int CPU_W = 2;
   localparam int LEN_W = 7;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_MIGRATE = 2'd2,
      OP_PICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_INVALID  = 2'd1,
      ST_NOCHANGE = 2'd2
   } status_type;

   typedef struct packed {
      op_type            operation;
      logic [TASK_W-1:0] task_id;
      logic [CPU_W-1:0]  target_cpu;
      logic [TASK_W-1:0] prev_task;
      logic              prev_is_idle;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [TASK_W-1:0] chosen_task;
      logic              chosen_is_idle;
      logic [LEN_W-1:0]  queue_length;
   } rsp_type;

endpackage

@@ hw/rtl/multi_queue_round_robin_scheduler_unit.sv @@
// Per-processor round-robin run queues kept as doubly linked lists in on-chip
// memories: a task record memory (queued flag and home processor), next and
// prior link memories, and a per-processor head/tail memory with flip-flop
// counts. One request is in flight at a time. Each request first reads the
// task record and links together with the head/tail entry of its target;
// a dequeue or migrate that goes ahead then reads the head/tail entry of the
// home processor, and each list change is written back in its own step,
// since unlink and relink of a migrate each need the single write port of
// both link memories. The result register holds a finished transaction
// while the next request is taken. After reset the task record memory is
// cleared entry by entry, during which req_stall is high.
module multi_queue_round_robin_scheduler_unit #(
   parameter int NUM_CPUS  = 4,
   parameter int NUM_TASKS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mqrrs_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mqrrs_pkg::rsp_type  rsp_data
);

   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int NW = $clog2(NUM_TASKS + 1);

   typedef struct packed {
      logic          queued;
      logic [CW-1:0] home;
   } trec_type;

   typedef struct packed {
      logic [TW-1:0] first;
      logic [TW-1:0] last;
   } crec_type;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_READ   = 6'b000100,
      S_UNLINK = 6'b001000,
      S_TAIL   = 6'b010000,
      S_FIN    = 6'b100000
   } state_type;

   // memories
   trec_type      tmem      [NUM_TASKS];
   logic [TW-1:0] next_mem  [NUM_TASKS];
   logic [TW-1:0] prior_mem [NUM_TASKS];
   crec_type      cmem      [NUM_CPUS];
   logic [NW-1:0] count_ff  [NUM_CPUS];

   state_type          state_ff, state_in;
   logic [TW-1:0]      clr_ff, clr_in;
   mqrrs_pkg::req_type req_ff, req_in;
   mqrrs_pkg::rsp_type res_ff, res_in;
   crec_type           tgt_rec_ff, tgt_rec_in;
   logic [NW-1:0]      tgt_cnt_ff, tgt_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mqrrs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   trec_type           tsk_rd_ff;
   logic [TW-1:0]      next_rd_ff;
   logic [TW-1:0]      prior_rd_ff;
   crec_type           cpu_rd_ff;
   logic [NW-1:0]      cnt_rd_ff;

   logic               t_we;
   logic [TW-1:0]      t_waddr;
   trec_type           t_wdata;
   logic               n_we;
   logic [TW-1:0]      n_waddr;
   logic [TW-1:0]      n_wdata;
   logic               p_we;
   logic [TW-1:0]      p_waddr;
   logic [TW-1:0]      p_wdata;
   logic               c_we;
   logic [CW-1:0]      c_waddr;
   crec_type           c_wdata;
   logic               k_we;
   logic [CW-1:0]      k_waddr;
   logic [NW-1:0]      k_wdata;
   logic               link_re;
   logic [TW-1:0]      link_raddr;
   logic               cpu_re;
   logic [CW-1:0]      cpu_raddr;

   logic               cpu_ok;
   logic               task_ok;
   logic               prev_ok;
   logic               home_hit;
   logic [TW-1:0]      task_idx;
   logic [TW-1:0]      prev_idx;
   logic [CW-1:0]      tgt_idx;

   assign task_idx = TW'(req_ff.task_id);
   assign prev_idx = TW'(req_ff.prev_task);
   assign tgt_idx  = CW'(req_ff.target_cpu);
   assign cpu_ok   = 32'(req_ff.target_cpu) < NUM_CPUS;
   assign task_ok  = 32'(req_ff.task_id) < NUM_TASKS;
   assign prev_ok  = 32'(req_ff.prev_task) < NUM_TASKS;
   assign home_hit = 32'(tsk_rd_ff.home) == 32'(req_ff.target_cpu);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic          tail_go;
      crec_type      tail_rec;
      logic [NW-1:0] tail_cnt;
      logic          is_first;
      logic          is_last;

      tail_go      = 1'b0;
      tail_rec     = cpu_rd_ff;
      tail_cnt     = cnt_rd_ff;
      is_first     = (cpu_rd_ff.first == task_idx);
      is_last      = (cpu_rd_ff.last == task_idx);
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      tgt_rec_in   = tgt_rec_ff;
      tgt_cnt_in   = tgt_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      t_we         = 1'b0;
      t_waddr      = task_idx;
      t_wdata      = '0;
      n_we         = 1'b0;
      n_waddr      = '0;
      n_wdata      = '0;
      p_we         = 1'b0;
      p_waddr      = '0;
      p_wdata      = '0;
      c_we         = 1'b0;
      c_waddr      = '0;
      c_wdata      = cpu_rd_ff;
      k_we         = 1'b0;
      k_waddr      = '0;
      k_wdata      = '0;
      link_re      = 1'b0;
      link_raddr   = TW'(req_data.task_id);
      cpu_re       = 1'b0;
      cpu_raddr    = CW'(req_data.target_cpu);

      unique case (state_ff)
         S_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
            if (clr_ff == TW'(NUM_TASKS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               link_re = 1'b1;
               cpu_re  = 1'b1;
               if (req_data.operation == mqrrs_pkg::OP_PICK) begin
                  link_raddr = TW'(req_data.prev_task);
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            tgt_rec_in = cpu_rd_ff;
            tgt_cnt_in = cnt_rd_ff;
            res_in = '0;
            res_in.status = mqrrs_pkg::ST_DONE;
            res_in.queue_length = cpu_ok ? mqrrs_pkg::LEN_W'(cnt_rd_ff) : '0;
            state_in = S_FIN;
            unique case (req_ff.operation)
               mqrrs_pkg::OP_ENQUEUE: begin
                  if (!cpu_ok || !task_ok || tsk_rd_ff.queued) begin
                     res_in.status = mqrrs_pkg::ST_NOCHANGE;
                  end else begin
                     tail_go = 1'b1;
                     res_in.queue_length = mqrrs_pkg::LEN_W'(cnt_rd_ff + 1'b1);
                  end
               end
               mqrrs_pkg::OP_DEQUEUE: begin
                  if (!task_ok || !tsk_rd_ff.queued) begin
                     res_in.status = mqrrs_pkg::ST_NOCHANGE;
                  end else begin
                     cpu_re    = 1'b1;
                     cpu_raddr = tsk_rd_ff.home;
                     state_in  = S_UNLINK;
                  end
               end
               mqrrs_pkg::OP_MIGRATE: begin
                  priority if (!cpu_ok || !task_ok) begin
                     res_in.status = mqrrs_pkg::ST_INVALID;
                  end else if (home_hit) begin
                     res_in.status = mqrrs_pkg::ST_NOCHANGE;
                  end else if (!tsk_rd_ff.queued) begin
                     res_in.status = mqrrs_pkg::ST_INVALID;
                  end else begin
                     cpu_re    = 1'b1;
                     cpu_raddr = tsk_rd_ff.home;
                     state_in  = S_UNLINK;
                  end
               end
               mqrrs_pkg::OP_PICK: begin
                  if (!cpu_ok || cnt_rd_ff == '0) begin
                     res_in.chosen_is_idle = 1'b1;
                  end else if (!req_ff.prev_is_idle && prev_ok && tsk_rd_ff.queued &&
                               home_hit && prev_idx != cpu_rd_ff.last) begin
                     res_in.chosen_task = mqrrs_pkg::TASK_W'(next_rd_ff);
                  end else begin
                     res_in.chosen_task = mqrrs_pkg::TASK_W'(cpu_rd_ff.first);
                  end
               end
            endcase
         end
         S_UNLINK: begin
            priority if (is_first && is_last) begin
               c_we = 1'b0;
            end else if (is_first) begin
               c_we          = 1'b1;
               c_wdata.first = next_rd_ff;
            end else if (is_last) begin
               c_we         = 1'b1;
               c_wdata.last = prior_rd_ff;
            end else begin
               n_we    = 1'b1;
               n_waddr = prior_rd_ff;
               n_wdata = next_rd_ff;
               p_we    = 1'b1;
               p_waddr = next_rd_ff;
               p_wdata = prior_rd_ff;
            end
            c_waddr = tsk_rd_ff.home;
            k_we    = 1'b1;
            k_waddr = tsk_rd_ff.home;
            k_wdata = (cnt_rd_ff != '0) ? cnt_rd_ff - 1'b1 : cnt_rd_ff;
            t_we    = 1'b1;
            t_wdata = '{queued: 1'b0, home: tsk_rd_ff.home};
            if (req_ff.operation == mqrrs_pkg::OP_MIGRATE) begin
               state_in = S_TAIL;
            end else begin
               if (home_hit) begin
                  res_in.queue_length = mqrrs_pkg::LEN_W'(k_wdata);
               end
               state_in = S_FIN;
            end
         end
         S_TAIL: begin
            tail_go  = 1'b1;
            tail_rec = tgt_rec_ff;
            tail_cnt = tgt_cnt_ff;
            res_in.queue_length = mqrrs_pkg::LEN_W'(tgt_cnt_ff + 1'b1);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
      endcase

      // append task at the tail of the target queue
      if (tail_go) begin
         c_we         = 1'b1;
         c_waddr      = tgt_idx;
         c_wdata      = tail_rec;
         c_wdata.last = task_idx;
         if (tail_cnt == '0) begin
            c_wdata.first = task_idx;
         end else begin
            n_we    = 1'b1;
            n_waddr = tail_rec.last;
            n_wdata = task_idx;
            p_we    = 1'b1;
            p_waddr = task_idx;
            p_wdata = tail_rec.last;
         end
         k_we    = 1'b1;
         k_waddr = tgt_idx;
         k_wdata = tail_cnt + 1'b1;
         t_we    = 1'b1;
         t_wdata = '{queued: 1'b1, home: tgt_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      tgt_rec_ff  <= tgt_rec_in;
      tgt_cnt_ff  <= tgt_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (k_we) begin
         count_ff[k_waddr] <= k_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         tmem[t_waddr] <= t_wdata;
      end
      if (link_re) begin
         tsk_rd_ff <= tmem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (n_we) begin
         next_mem[n_waddr] <= n_wdata;
      end
      if (link_re) begin
         next_rd_ff <= next_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         prior_mem[p_waddr] <= p_wdata;
      end
      if (link_re) begin
         prior_rd_ff <= prior_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         cmem[c_waddr] <= c_wdata;
      end
      if (cpu_re) begin
         cpu_rd_ff <= cmem[cpu_raddr];
         cnt_rd_ff <= count_ff[cpu_raddr];
      end
   end

   // a finished transaction reaches the result register once it is free
   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished transaction not delivered");

   // unlinking only happens on a non-empty home queue
   a_unlink_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UNLINK) |-> (cnt_rd_ff != '0))
      else $error("unlink from an empty queue");

   // an idle pick carries no task and always completes
   a_idle_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.chosen_is_idle |->
         (rsp_data_ff.chosen_task == '0) && (rsp_data_ff.status == mqrrs_pkg::ST_DONE))
      else $error("idle pick with a task or bad status");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int NUM_CPUS = 4;
   localparam int NUM_TASKS = 64;
   localparam int STALL_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   mqrrs_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   mqrrs_pkg::rsp_type rsp_data;

   multi_queue_round_robin_scheduler_unit #(
      .NUM_CPUS  (NUM_CPUS),
      .NUM_TASKS (NUM_TASKS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // run queue shadow state
   logic                        rq_queued [NUM_TASKS];
   logic [mqrrs_pkg::CPU_W-1:0]  rq_home   [NUM_TASKS];
   logic [mqrrs_pkg::TASK_W-1:0] rq_next   [NUM_TASKS];
   logic [mqrrs_pkg::TASK_W-1:0] rq_prior  [NUM_TASKS];
   logic [mqrrs_pkg::TASK_W-1:0] rq_first  [NUM_CPUS];
   logic [mqrrs_pkg::TASK_W-1:0] rq_last   [NUM_CPUS];
   logic [mqrrs_pkg::LEN_W-1:0]  rq_count  [NUM_CPUS];

   mqrrs_pkg::rsp_type pending_rsp [$];
   int      errors = 0;
   bit      steady = 1'b0;
   int      quiet_cycles = 0;

   function automatic void rq_link_tail(logic [mqrrs_pkg::CPU_W-1:0] cpu,
                                        logic [mqrrs_pkg::TASK_W-1:0] t);
      if (rq_count[cpu] == 0) begin
         rq_first[cpu] = t;
      end else begin
         rq_next[rq_last[cpu]] = t;
         rq_prior[t] = rq_last[cpu];
      end
      rq_last[cpu] = t;
      rq_count[cpu] = rq_count[cpu] + 1'b1;
      rq_queued[t] = 1'b1;
      rq_home[t] = cpu;
   endfunction

   function automatic void rq_unlink(logic [mqrrs_pkg::TASK_W-1:0] t);
      logic [mqrrs_pkg::CPU_W-1:0] cpu;
      logic             is_first;
      logic             is_last;
      cpu = rq_home[t];
      is_first = (rq_first[cpu] == t);
      is_last = (rq_last[cpu] == t);
      if (is_first && !is_last) begin
         rq_first[cpu] = rq_next[t];
      end else if (!is_first && is_last) begin
         rq_last[cpu] = rq_prior[t];
      end else if (!is_first && !is_last) begin
         rq_next[rq_prior[t]] = rq_next[t];
         rq_prior[rq_next[t]] = rq_prior[t];
      end
      if (rq_count[cpu] != 0) rq_count[cpu] = rq_count[cpu] - 1'b1;
      rq_queued[t] = 1'b0;
   endfunction

   function automatic mqrrs_pkg::rsp_type sched_predict(mqrrs_pkg::req_type r);
      mqrrs_pkg::rsp_type res;
      logic    in_queue;
      res = '0;
      res.status = mqrrs_pkg::ST_DONE;
      case (r.operation)
         mqrrs_pkg::OP_ENQUEUE: begin
            if (rq_queued[r.task_id]) res.status = mqrrs_pkg::ST_NOCHANGE;
            else rq_link_tail(r.target_cpu, r.task_id);
         end
         mqrrs_pkg::OP_DEQUEUE: begin
            if (!rq_queued[r.task_id]) res.status = mqrrs_pkg::ST_NOCHANGE;
            else rq_unlink(r.task_id);
         end
         mqrrs_pkg::OP_MIGRATE: begin
            if (rq_home[r.task_id] == r.target_cpu) begin
               res.status = mqrrs_pkg::ST_NOCHANGE;
            end else if (!rq_queued[r.task_id]) begin
               res.status = mqrrs_pkg::ST_INVALID;
            end else begin
               rq_unlink(r.task_id);
               rq_link_tail(r.target_cpu, r.task_id);
            end
         end
         default: begin
            if (rq_count[r.target_cpu] == 0) begin
               res.chosen_is_idle = 1'b1;
            end else begin
               in_queue = !r.prev_is_idle && rq_queued[r.prev_task] &&
                          (rq_home[r.prev_task] == r.target_cpu);
               if (in_queue && r.prev_task != rq_last[r.target_cpu])
                  res.chosen_task = rq_next[r.prev_task];
               else
                  res.chosen_task = rq_first[r.target_cpu];
            end
         end
      endcase
      res.queue_length = rq_count[r.target_cpu];
      return res;
   endfunction

   function automatic int draw_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic mqrrs_pkg::req_type make_req(mqrrs_pkg::op_type op, int t, int cpu,
                                                   int prev, bit prev_idle);
      mqrrs_pkg::req_type r;
      r.operation = op;
      r.task_id = mqrrs_pkg::TASK_W'(t);
      r.target_cpu = mqrrs_pkg::CPU_W'(cpu);
      r.prev_task = mqrrs_pkg::TASK_W'(prev);
      r.prev_is_idle = prev_idle;
      return r;
   endfunction

   function automatic int choose_task(bit want_queued, int cpu);
      int hits [$];
      for (int i = 0; i < NUM_TASKS; i++)
         if (rq_queued[i] == want_queued && (cpu < 0 || rq_home[i] == cpu))
            hits.push_back(i);
      if (hits.size() == 0) return $urandom_range(0, NUM_TASKS - 1);
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   function automatic mqrrs_pkg::req_type random_req();
      logic [31:0] noise;
      int roll;
      int cpu;
      int t;
      int prev;
      roll = $urandom_range(0, 99);
      cpu = $urandom_range(0, NUM_CPUS - 1);
      prev = $urandom_range(0, NUM_TASKS - 1);
      if (roll < 12) begin
         noise = $urandom;
         return mqrrs_pkg::req_type'(noise[$bits(mqrrs_pkg::req_type)-1:0]);
      end
      if (roll < 34)
         return make_req(mqrrs_pkg::OP_ENQUEUE, choose_task(1'b0, -1), cpu, prev,
                         1'($urandom_range(0, 1)));
      if (roll < 54)
         return make_req(mqrrs_pkg::OP_DEQUEUE, choose_task(1'b1, -1), cpu, prev,
                         1'($urandom_range(0, 1)));
      if (roll < 72) begin
         t = choose_task(1'b1, -1);
         if ($urandom_range(0, 4) != 0) cpu = (rq_home[t] + 1 + $urandom_range(0, 2)) % NUM_CPUS;
         return make_req(mqrrs_pkg::OP_MIGRATE, t, cpu, prev, 1'($urandom_range(0, 1)));
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) prev = choose_task(1'b1, cpu);
      else if (roll < 80) prev = rq_last[cpu];
      return make_req(mqrrs_pkg::OP_PICK, $urandom_range(0, NUM_TASKS - 1), cpu, prev,
                      $urandom_range(0, 99) < 15);
   endfunction

   task automatic send_item(mqrrs_pkg::req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(sched_predict(r));
   endtask

   task automatic test_directed();
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_MIGRATE, 5, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_MIGRATE, 5, 2, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_DEQUEUE, 63, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 0, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 63, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 0, 2, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 21, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 0, 1'b1));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 21, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 42, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 42, 3, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 42, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_MIGRATE, 63, 3, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_MIGRATE, 42, 3, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 7, 1, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 8, 1, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_ENQUEUE, 9, 1, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_DEQUEUE, 8, 1, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_DEQUEUE, 9, 1, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 1, 7, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_DEQUEUE, 0, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_DEQUEUE, 21, 0, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 0, 21, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_DEQUEUE, 42, 3, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_MIGRATE, 42, 1, 0, 1'b0));
      send_item(make_req(mqrrs_pkg::OP_PICK, 0, 3, 63, 1'b0));
   endtask

   task automatic test_full_queue();
      int order [NUM_TASKS];
      int cpu;
      int j;
      int tmp;
      cpu = $urandom_range(0, NUM_CPUS - 1);
      for (int i = 0; i < NUM_TASKS; i++)
         if (rq_queued[i]) send_item(make_req(mqrrs_pkg::OP_DEQUEUE, i, cpu, 0, 1'b0));
      for (int i = 0; i < NUM_TASKS; i++) order[i] = i;
      for (int i = NUM_TASKS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < NUM_TASKS; i++)
         send_item(make_req(mqrrs_pkg::OP_ENQUEUE, order[i], cpu, $urandom_range(0, 63), 1'b0));
      for (int i = 0; i < 24; i++)
         send_item(make_req(mqrrs_pkg::OP_PICK, 0, cpu, $urandom_range(0, 63),
                            $urandom_range(0, 99) < 15));
      for (int i = 0; i < NUM_TASKS; i++)
         send_item(make_req(mqrrs_pkg::OP_DEQUEUE, order[(i * 29) % NUM_TASKS], cpu, 0, 1'b0));
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 400; i++) send_item(random_req());
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      for (int i = 0; i < 80; i++) send_item(random_req());
      steady = 1'b0;
   endtask

   initial begin : rsp_stall_driver
      int open_len;
      int shut_len;
      @(posedge clock);
      forever begin
         open_len = 1 + $urandom_range(0, 5);
         rsp_stall <= 1'b0;
         repeat (open_len) @(posedge clock);
         shut_len = draw_gap();
         if (shut_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (shut_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      mqrrs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transaction %h", rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.chosen_task !== want.chosen_task) begin
               $error("chosen_task: expected %0d, actual %0d",
                      want.chosen_task, rsp_data.chosen_task);
               errors++;
            end
            if (rsp_data.chosen_is_idle !== want.chosen_is_idle) begin
               $error("chosen_is_idle: expected %0d, actual %0d",
                      want.chosen_is_idle, rsp_data.chosen_is_idle);
               errors++;
            end
            if (rsp_data.queue_length !== want.queue_length) begin
               $error("queue_length: expected %0d, actual %0d",
                      want.queue_length, rsp_data.queue_length);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         rq_queued[i] = 1'b0;
         rq_home[i] = '0;
         rq_next[i] = '0;
         rq_prior[i] = '0;
      end
      for (int i = 0; i < NUM_CPUS; i++) begin
         rq_first[i] = '0;
         rq_last[i] = '0;
         rq_count[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_queue();
      test_random_mix();
      test_back_to_back();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
